### rtl/group_soft_threshold_shrink_assert.svh
// Assertion macros shared by the RTL of the group shrink block.
`ifndef GROUP_SOFT_THRESHOLD_SHRINK_ASSERT_SVH
`define GROUP_SOFT_THRESHOLD_SHRINK_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define GTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define GTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/gts_pkg.sv
`default_nettype none
package gts_pkg;
	localparam int LANES   = 4;
	localparam int DATA_W  = 32;
	localparam int CFG_W   = 31;
	localparam int GRP_W   = 3;
	localparam int SQ_W    = 64;
	localparam int SUM_W   = 66;
	localparam int NORM_W  = 33;
	localparam int PROD_W  = 63;
	localparam int Q_W     = 32;
	localparam int DIV_W   = 65;

	// configuration register indexes
	localparam logic [1:0] CFG_THRESHOLD_ONE = 2'd0;
	localparam logic [1:0] CFG_THRESHOLD_TWO = 2'd1;
	localparam logic [1:0] CFG_GROUPS_IN_USE = 2'd2;

	typedef struct packed {
		logic [7:0]               row_index;
		logic [7:0]               column_index;
		logic signed [DATA_W-1:0] entry_zero;
		logic signed [DATA_W-1:0] entry_one;
		logic signed [DATA_W-1:0] entry_two;
		logic signed [DATA_W-1:0] entry_three;
	} gts_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] shrunk_zero;
		logic signed [DATA_W-1:0] shrunk_one;
		logic signed [DATA_W-1:0] shrunk_two;
		logic signed [DATA_W-1:0] shrunk_three;
	} gts_out_t;
endpackage
`default_nettype wire

### rtl/gts_lane.sv
`default_nettype none
// One lane front end: soft threshold (s1), then square and threshold-two product (s2).
module gts_lane (
	input  wire logic                             clk,
	input  wire logic                             en,
	input  wire logic signed [gts_pkg::DATA_W-1:0] entry,
	input  wire logic                             diag,
	input  wire logic [gts_pkg::CFG_W-1:0]        thr_one,
	input  wire logic [gts_pkg::CFG_W-1:0]        thr_two,
	output logic [gts_pkg::DATA_W-1:0]            mag_s2,
	output logic                                  neg_s2,
	output logic [gts_pkg::SQ_W-1:0]              sq_s2,
	output logic [gts_pkg::PROD_W-1:0]            prod_s2
);
	logic [gts_pkg::DATA_W-1:0] abs_x;
	logic [gts_pkg::DATA_W-1:0] mag;
	logic [gts_pkg::DATA_W-1:0] mag_s1;
	logic                       neg_s1;

	// magnitude, thresholded off the diagonal
	always_comb begin
		abs_x = entry[gts_pkg::DATA_W-1] ? (~entry + 1'b1) : entry;
		if (diag)
			mag = abs_x;
		else if (abs_x > {1'b0, thr_one})
			mag = abs_x - {1'b0, thr_one};
		else
			mag = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag;
			neg_s1 <= entry[gts_pkg::DATA_W-1];
		end
	end

	// square for the norm, product for the shrink amount
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			sq_s2   <= mag_s1 * mag_s1;
			prod_s2 <= gts_pkg::PROD_W'(mag_s1 * thr_two);
		end
	end
endmodule
`default_nettype wire

### rtl/gts_isqrt.sv
`default_nettype none
// Pipelined integer square root, one result bit per stage, side data rides along.
module gts_isqrt #(
	parameter int SIDE_W = 1
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [gts_pkg::SUM_W-1:0]  radicand,
	input  wire logic [SIDE_W-1:0]          side_in,
	output logic [gts_pkg::NORM_W-1:0]      root,
	output logic [SIDE_W-1:0]               side_out
);
	localparam int N = gts_pkg::NORM_W;

	logic [gts_pkg::SUM_W-1:0] rem_s  [N];
	logic [gts_pkg::SUM_W-1:0] root_s [N];
	logic [SIDE_W-1:0]         side_s [N];

	for (genvar j = 0; j < N; j++) begin : g_stage
		localparam int K = N - 1 - j;
		logic [gts_pkg::SUM_W-1:0] rem_p, root_p, trial, rem_n, root_n;
		logic [SIDE_W-1:0]         side_p;
		if (j == 0) begin : g_first
			assign rem_p  = radicand;
			assign root_p = '0;
			assign side_p = side_in;
		end else begin : g_next
			assign rem_p  = rem_s[j-1];
			assign root_p = root_s[j-1];
			assign side_p = side_s[j-1];
		end
		// try the next root bit
		always_comb begin
			trial = root_p + (gts_pkg::SUM_W'(1) << (2 * K));
			if (rem_p >= trial) begin
				rem_n  = rem_p - trial;
				root_n = (root_p >> 1) + (gts_pkg::SUM_W'(1) << (2 * K));
			end else begin
				rem_n  = rem_p;
				root_n = root_p >> 1;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= rem_n;
				root_s[j] <= root_n;
				side_s[j] <= side_p;
			end
		end
	end

	assign root     = root_s[N-1][gts_pkg::NORM_W-1:0];
	assign side_out = side_s[N-1];
endmodule
`default_nettype wire

### rtl/gts_div.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, side data rides along.
module gts_div #(
	parameter int SIDE_W = 1
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [gts_pkg::PROD_W-1:0]  num,
	input  wire logic [gts_pkg::NORM_W-1:0]  den,
	input  wire logic [SIDE_W-1:0]           side_in,
	output logic [gts_pkg::Q_W-1:0]          quot,
	output logic [SIDE_W-1:0]                side_out
);
	localparam int N = gts_pkg::Q_W;

	logic [gts_pkg::DIV_W-1:0]  rem_s  [N];
	logic [gts_pkg::NORM_W-1:0] den_s  [N];
	logic [gts_pkg::Q_W-1:0]    quot_s [N];
	logic [SIDE_W-1:0]          side_s [N];

	for (genvar j = 0; j < N; j++) begin : g_stage
		localparam int I = N - 1 - j;
		logic [gts_pkg::DIV_W-1:0]  rem_p, shifted, rem_n;
		logic [gts_pkg::NORM_W-1:0] den_p;
		logic [gts_pkg::Q_W-1:0]    quot_p, quot_n;
		logic [SIDE_W-1:0]          side_p;
		if (j == 0) begin : g_first
			assign rem_p  = gts_pkg::DIV_W'(num);
			assign den_p  = den;
			assign quot_p = '0;
			assign side_p = side_in;
		end else begin : g_next
			assign rem_p  = rem_s[j-1];
			assign den_p  = den_s[j-1];
			assign quot_p = quot_s[j-1];
			assign side_p = side_s[j-1];
		end
		// subtract the shifted divisor where it fits
		always_comb begin
			shifted = gts_pkg::DIV_W'(den_p) << I;
			rem_n   = rem_p;
			quot_n  = quot_p;
			if (rem_p >= shifted) begin
				rem_n     = rem_p - shifted;
				quot_n[I] = 1'b1;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= rem_n;
				den_s[j]  <= den_p;
				quot_s[j] <= quot_n;
				side_s[j] <= side_p;
			end
		end
	end

	assign quot     = quot_s[N-1];
	assign side_out = side_s[N-1];
endmodule
`default_nettype wire

### rtl/group_soft_threshold_shrink.sv
// Sparse group lasso shrink for one upper-triangle position of up to four matrices.
// Input channel: item_valid / item_stall / item. An item carries the position and
// one Q16.16 entry per matrix. Output channel: result_valid / result_stall / result,
// one beat per item, in order. Configuration: cfg_we writes cfg_data into the
// register picked by cfg_index (threshold one, threshold two, groups in use);
// write only while no item is in flight.
// Throughput: one item per cycle while item_stall is low. From accept to result_valid
// an item passes two lane stages, one sum stage, the 33-stage square root, the
// 32-stage divider and the output register.
// Four lanes threshold and square in parallel, a merge stage sums the squares,
// and the lanes then divide in parallel for the shrink.
// Reset clears thresholds to zero, groups in use to four, and empties the pipe.
// A stalled result holds; a skid register takes one more beat, after which
// item_stall rises and the whole pipeline freezes until the result is taken.
`default_nettype none
module group_soft_threshold_shrink #(
	parameter int MAX_GROUPS = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_stall,
	input  wire gts_pkg::gts_in_t             item,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output gts_pkg::gts_out_t                 result,
	input  wire logic                         cfg_we,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [gts_pkg::CFG_W-1:0]    cfg_data
);
	`include "group_soft_threshold_shrink_assert.svh"

	localparam int L      = gts_pkg::LANES;
	localparam int DW     = gts_pkg::DATA_W;
	localparam int LANE_W = gts_pkg::PROD_W + DW + 1;
	localparam int DSIDE  = DW + 2;
	localparam int LAT    = 3 + gts_pkg::NORM_W + gts_pkg::Q_W;

	logic [gts_pkg::CFG_W-1:0] thr_one_q, thr_two_q;
	logic [gts_pkg::GRP_W-1:0] groups_q;
	logic [gts_pkg::GRP_W-1:0] used;
	logic [L-1:0]              lane_used;

	logic             en, accept, diag;
	logic [LAT-1:0]   vld_s;
	logic [L-1:0][DW-1:0]             entry_w;
	logic [L-1:0][DW-1:0]             mag_s2;
	logic [L-1:0]                     neg_s2;
	logic [L-1:0][gts_pkg::SQ_W-1:0]  sq_s2;
	logic [L-1:0][gts_pkg::PROD_W-1:0] prod_s2;
	logic [1:0]                       diag_q;

	logic [gts_pkg::SUM_W-1:0]        sum_s3, sum_c;
	logic [L-1:0][LANE_W-1:0]         lane_s3;
	logic                             diag_s3;

	logic [L*LANE_W:0]                sq_side_in, sq_side_out;
	logic [gts_pkg::NORM_W-1:0]       norm;
	logic                             sq_diag, shrink, ok;

	logic [L-1:0][gts_pkg::Q_W-1:0]   quot;
	logic [L-1:0][DSIDE-1:0]          dv_side;
	logic [L-1:0][DW-1:0]             res_c;
	gts_pkg::gts_out_t                res_w, skid_q;
	logic                             skid_full_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_one_q <= '0;
			thr_two_q <= '0;
			groups_q  <= gts_pkg::GRP_W'(4);
		end else if (cfg_we) begin
			unique case (cfg_index)
				gts_pkg::CFG_THRESHOLD_ONE: thr_one_q <= cfg_data;
				gts_pkg::CFG_THRESHOLD_TWO: thr_two_q <= cfg_data;
				gts_pkg::CFG_GROUPS_IN_USE: groups_q  <= cfg_data[gts_pkg::GRP_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp lanes in use
	always_comb begin
		used = groups_q;
		if (32'(used) > MAX_GROUPS) used = gts_pkg::GRP_W'(MAX_GROUPS);
		if (32'(used) > L) used = gts_pkg::GRP_W'(L);
		for (int k = 0; k < L; k++)
			lane_used[k] = 32'(k) < 32'(used);
	end

	assign en         = !skid_full_q;
	assign item_stall = skid_full_q;
	assign accept     = item_valid && !item_stall;
	assign diag       = item.row_index == item.column_index;
	assign entry_w    = {item.entry_three, item.entry_two, item.entry_one, item.entry_zero};

	// advance the valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[LAT-2:0], accept};
	end

	for (genvar k = 0; k < L; k++) begin : g_lane
		gts_lane u_lane (
			.clk     (clk),
			.en      (en),
			.entry   (entry_w[k]),
			.diag    (diag),
			.thr_one (thr_one_q),
			.thr_two (thr_two_q),
			.mag_s2  (mag_s2[k]),
			.neg_s2  (neg_s2[k]),
			.sq_s2   (sq_s2[k]),
			.prod_s2 (prod_s2[k])
		);
	end

	// merge: sum squares of the lanes in use
	always_comb begin
		sum_c = '0;
		for (int k = 0; k < L; k++)
			if (lane_used[k]) sum_c = sum_c + gts_pkg::SUM_W'(sq_s2[k]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diag_q  <= {diag_q[0], diag};
			sum_s3  <= sum_c;
			diag_s3 <= diag_q[1];
			for (int k = 0; k < L; k++)
				lane_s3[k] <= {prod_s2[k], mag_s2[k], neg_s2[k]};
		end
	end

	assign sq_side_in = {diag_s3, lane_s3};

	gts_isqrt #(.SIDE_W(L*LANE_W+1)) u_isqrt (
		.clk      (clk),
		.en       (en),
		.radicand (sum_s3),
		.side_in  (sq_side_in),
		.root     (norm),
		.side_out (sq_side_out)
	);

	// decide shrink versus zero
	assign sq_diag = sq_side_out[L*LANE_W];
	assign shrink  = !sq_diag && (norm > gts_pkg::NORM_W'(thr_two_q));
	assign ok      = sq_diag || shrink;

	for (genvar k = 0; k < L; k++) begin : g_div
		logic [LANE_W-1:0]         lane_w;
		logic [gts_pkg::PROD_W-1:0] num;
		logic [gts_pkg::NORM_W-1:0] den;
		assign lane_w = sq_side_out[k*LANE_W +: LANE_W];
		assign num    = shrink ? lane_w[LANE_W-1 -: gts_pkg::PROD_W] : '0;
		assign den    = shrink ? norm : gts_pkg::NORM_W'(1);
		gts_div #(.SIDE_W(DSIDE)) u_div (
			.clk      (clk),
			.en       (en),
			.num      (num),
			.den      (den),
			.side_in  ({ok, lane_w[DW:0]}),
			.quot     (quot[k]),
			.side_out (dv_side[k])
		);

		// apply sign, saturate, mask unused lanes
		always_comb begin
			logic [DW-1:0] m;
			m = dv_side[k][DW+1] ? (dv_side[k][DW:1] - quot[k]) : '0;
			if (!lane_used[k])
				res_c[k] = '0;
			else if (dv_side[k][0])
				res_c[k] = ~m + 1'b1;
			else if (m[DW-1])
				res_c[k] = {1'b0, {(DW-1){1'b1}}};
			else
				res_c[k] = m;
		end
	end

	assign res_w = {res_c[0], res_c[1], res_c[2], res_c[3]};

	// output register and skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			skid_full_q  <= 1'b0;
		end else if (skid_full_q) begin
			if (!result_stall) begin
				result_valid <= 1'b1;
				skid_full_q  <= 1'b0;
			end
		end else if (vld_s[LAT-1]) begin
			if (!result_valid || !result_stall)
				result_valid <= 1'b1;
			else
				skid_full_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (!result_stall) result <= skid_q;
		end else if (vld_s[LAT-1]) begin
			if (!result_valid || !result_stall)
				result <= res_w;
			else
				skid_q <= res_w;
		end
	end

	`GTS_ASSERT_NOW(a_skid_needs_out, skid_full_q, result_valid, "skid full without a result")
	`GTS_ASSERT_NEXT(a_frozen_pipe, skid_full_q && result_stall, $stable(vld_s),
		"pipeline moved while frozen")
	`GTS_ASSERT_NOW(a_unused_lane_zero, result_valid && !lane_used[3],
		result.shrunk_three == '0, "unused lane gave a nonzero result")
endmodule
`default_nettype wire
